### rtl/stfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stfg_pkg;

  // Field and state widths.
  localparam int RATE_W    = 16;
  localparam int AMP_W     = 15;
  localparam int FREQ_W    = 15;
  localparam int MS_W      = 16;
  localparam int SAMPLE_W  = 16;
  localparam int SINE_W    = 15;
  localparam int PHASE_W   = 32;
  localparam int POS_W     = 22;
  localparam int FADE_W    = 9;
  localparam int PROD_W    = RATE_W + MS_W;
  localparam int MAG_W     = SINE_W + AMP_W;
  localparam int ENVP_W    = MAG_W + FADE_W;
  localparam int CFG_IDX_W = 1;

  // Serial divider sizing.
  localparam int DIV_W     = 48;
  localparam int DIVISOR_W = 16;
  localparam int DIV_CNT_W = 6;

  // Reciprocals for the divides by 1000 and by 100. Each one is exact over the
  // full range of its operand: a 32-bit product and a 16-bit rate.
  localparam int MS_RCP_W   = 29;
  localparam int MS_RCP_SH  = 38;
  localparam int RATE_RCP_W = 17;
  localparam int RATE_RCP_SH = 23;

  localparam logic [MS_RCP_W-1:0]   MS_RCP   = 29'd274877907;
  localparam logic [RATE_RCP_W-1:0] RATE_RCP = 17'd83887;

  // Command and register codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 1'b1;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd24000;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd16000;

  localparam logic [POS_W-1:0]  TOTAL_MAX = 22'h3F_FFFF;
  localparam logic [FADE_W-1:0] FADE_MAX  = 9'd511;

  localparam logic [DIV_CNT_W-1:0] ITERS_STEP  = 6'd48;
  localparam logic [DIV_CNT_W-1:0] ITERS_ENV   = 6'd24;

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic              cmd;
    logic [FREQ_W-1:0] freq_hz;
    logic [PROD_W-1:0] rate_ms;
  } q_entry_t;

  typedef struct packed {
    logic                 go;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TOTAL,
    BK_FADE,
    BK_STEP_GO,
    BK_STEP_WAIT,
    BK_MAG,
    BK_ENV,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_OUT
  } back_state_t;

  // Quarter-wave sine magnitude for entry q of a table of 2**log2n entries.
  // Evaluated at elaboration only, to fill the sine table. The k-th Taylor
  // term is divided by (2k)(2k+1).
  function automatic logic [SINE_W-1:0] quarter_sine(input int q, input int log2n);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (PI_Q30 * 64'd2 * 64'(q)) >> log2n;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 12; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        9:       term = term / 64'd342;
        10:      term = term / 64'd420;
        11:      term = term / 64'd506;
        default: term = term / 64'd600;
      endcase
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum <= 0) begin
      r = 64'd0;
    end else begin
      r = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/stfg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stfg_front (
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_cmd,
  input  wire logic [stfg_pkg::FREQ_W-1:0]       in_freq_hz,
  input  wire logic [stfg_pkg::MS_W-1:0]         in_duration_ms,
  input  wire logic [stfg_pkg::RATE_W-1:0]       tone_rate,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output stfg_pkg::q_entry_t                     q_entry
);

  logic [stfg_pkg::PROD_W-1:0] rate_ms;

  // The sample count before the divide by 1000 is formed here, so the back
  // starts a tone with the product already in hand.
  assign rate_ms  = tone_rate * in_duration_ms;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.cmd = in_cmd;
    if (in_cmd == stfg_pkg::CMD_START) begin
      q_entry.freq_hz = in_freq_hz;
      q_entry.rate_ms = rate_ms;
    end else begin
      q_entry.freq_hz = '0;
      q_entry.rate_ms = '0;
    end
  end

endmodule

`default_nettype wire

### rtl/stfg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stfg_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire stfg_pkg::q_entry_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output stfg_pkg::q_entry_t      pop_data,
  output logic                    empty
);

  localparam int DEPTH = stfg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  stfg_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/stfg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module stfg_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stfg_pkg::div_req_t req,
  output stfg_pkg::div_rsp_t      rsp
);

  localparam int W  = stfg_pkg::DIV_W;
  localparam int DW = stfg_pkg::DIVISOR_W;
  localparam int CW = stfg_pkg::DIV_CNT_W;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [W-1:0]  sh_r;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_nxt;
  logic [W-1:0]  sh_nxt;

  // Restoring division, one quotient bit per cycle. The requester aligns the
  // dividend to the top of the shift register, so after the last step the
  // register holds the zero-extended quotient.
  always_comb begin
    trial   = {rem_r, sh_r[W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
    sh_nxt  = {sh_r[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= '0;
      den_r <= req.divisor;
      sh_r  <= req.dividend;
      cnt_r <= req.iters;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = sh_r;

endmodule

`default_nettype wire

### rtl/stfg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stfg_back #(
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [stfg_pkg::RATE_W-1:0]           tone_rate,
  input  wire logic [stfg_pkg::AMP_W-1:0]            amplitude,
  input  wire logic                                  q_valid,
  input  wire stfg_pkg::q_entry_t                    q_data,
  output logic                                       q_pop,
  output stfg_pkg::div_req_t                         div_req,
  input  wire stfg_pkg::div_rsp_t                    div_rsp,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [stfg_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                                       out_last
);

  localparam int LOG2N   = $clog2(SINE_TABLE_SIZE);
  localparam int QA_W    = LOG2N - 1;
  localparam int QUARTER = SINE_TABLE_SIZE / 4;
  localparam int POS_W   = stfg_pkg::POS_W;
  localparam int FADE_W  = stfg_pkg::FADE_W;
  localparam int SINE_W  = stfg_pkg::SINE_W;
  localparam int TOTP_W  = stfg_pkg::PROD_W + stfg_pkg::MS_RCP_W;
  localparam int FADEP_W = stfg_pkg::RATE_W + stfg_pkg::RATE_RCP_W;

  localparam logic [QA_W-1:0] QUARTER_V = QA_W'(QUARTER);
  localparam logic [QA_W:0]   HALF_V    = (QA_W + 1)'(SINE_TABLE_SIZE / 2);

  // Quarter-wave table, entries 0 through a quarter period inclusive.
  typedef logic [SINE_W-1:0] qtab_t [QUARTER + 1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= QUARTER; i++) begin
      t[i] = stfg_pkg::quarter_sine(i, LOG2N);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  stfg_pkg::back_state_t state_r;
  stfg_pkg::back_state_t state_nxt;

  // Tone state.
  logic [stfg_pkg::PHASE_W-1:0] phase_acc_r;
  logic [stfg_pkg::PHASE_W-1:0] step_r;
  logic [POS_W-1:0]             position_r;
  logic [POS_W-1:0]             total_r;
  logic [FADE_W-1:0]            fade_r;

  // Work registers.
  logic [stfg_pkg::PROD_W-1:0]  work_prod_r;
  logic [stfg_pkg::FREQ_W-1:0]  work_freq_r;
  logic [SINE_W-1:0]            rom_mag_r;
  logic                         rom_neg_r;
  logic [stfg_pkg::MAG_W-1:0]   mag_r;
  logic [stfg_pkg::MAG_W-1:0]   mag_nxt;
  logic [stfg_pkg::ENVP_W-1:0]  envp_r;
  logic [stfg_pkg::ENVP_W-1:0]  envp_nxt;
  logic [FADE_W-1:0]            env_m_r;
  logic                         use_env_r;
  logic [SINE_W-1:0]            res_r;
  logic                         out_valid_r;
  logic [stfg_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                         out_last_r;

  logic                         tick_runs;
  logic                         is_start;
  logic                         load_out;
  logic                         slot_free;

  logic [LOG2N-1:0]             rom_addr;
  logic [QA_W-1:0]              rom_idx;
  logic [QA_W:0]                mirror;
  logic [QA_W-1:0]              q_sel;

  logic [POS_W-1:0]             fade_ext;
  logic [POS_W-1:0]             tail_d;
  logic                         in_head;
  logic                         in_tail;

  logic [TOTP_W-1:0]            tot_prod;
  logic [POS_W:0]               tot_quo;
  logic [FADEP_W-1:0]           fade_prod;
  logic [FADE_W:0]              fade_quo;
  logic [POS_W-1:0]             total_sat;
  logic [POS_W-1:0]             half_total;
  logic [POS_W-1:0]             fade_raw;
  logic [POS_W-1:0]             fade_min;
  logic [FADE_W-1:0]            fade_nxt;
  logic [stfg_pkg::SAMPLE_W-1:0] res_ext;

  assign tick_runs = (position_r < total_r);
  assign is_start  = (q_data.cmd == stfg_pkg::CMD_START);
  assign slot_free = !out_valid_r || !out_stall;

  // Sine lookup: the top phase bits pick a half and a place in it; the
  // second quarter of each half mirrors the first.
  always_comb begin
    rom_addr = phase_acc_r[stfg_pkg::PHASE_W-1 -: LOG2N];
    rom_idx  = rom_addr[QA_W-1:0];
    mirror   = HALF_V - {1'b0, rom_idx};
    q_sel    = (rom_idx <= QUARTER_V) ? rom_idx : mirror[QA_W-1:0];
  end

  // Envelope selection for the current position.
  always_comb begin
    fade_ext = {{(POS_W - FADE_W){1'b0}}, fade_r};
    tail_d   = total_r - position_r - 22'd1;
    in_head  = (position_r < fade_ext);
    in_tail  = (position_r >= (total_r - fade_ext));
  end

  // Tone setup: sample count and fade length by reciprocal multiplication.
  always_comb begin
    tot_prod   = work_prod_r * stfg_pkg::MS_RCP;
    tot_quo    = tot_prod[TOTP_W-1:stfg_pkg::MS_RCP_SH];
    total_sat  = tot_quo[POS_W] ? stfg_pkg::TOTAL_MAX : tot_quo[POS_W-1:0];
    fade_prod  = tone_rate * stfg_pkg::RATE_RCP;
    fade_quo   = fade_prod[FADEP_W-1:stfg_pkg::RATE_RCP_SH];
    half_total = {1'b0, total_r[POS_W-1:1]};
    fade_raw   = {{(POS_W - FADE_W - 1){1'b0}}, fade_quo};
    fade_min   = (fade_raw > half_total) ? half_total : fade_raw;
    fade_nxt   = (fade_min > {{(POS_W - FADE_W){1'b0}}, stfg_pkg::FADE_MAX})
                 ? stfg_pkg::FADE_MAX : fade_min[FADE_W-1:0];
  end

  assign mag_nxt  = rom_mag_r * amplitude;
  assign envp_nxt = mag_r * env_m_r;
  assign res_ext  = {1'b0, res_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stfg_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (is_start) begin
            state_nxt = stfg_pkg::BK_TOTAL;
          end else if (tick_runs) begin
            state_nxt = stfg_pkg::BK_MAG;
          end
        end
      end
      stfg_pkg::BK_TOTAL:    state_nxt = stfg_pkg::BK_FADE;
      stfg_pkg::BK_FADE: begin
        state_nxt = (tone_rate == '0) ? stfg_pkg::BK_IDLE : stfg_pkg::BK_STEP_GO;
      end
      stfg_pkg::BK_STEP_GO:  state_nxt = stfg_pkg::BK_STEP_WAIT;
      stfg_pkg::BK_STEP_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = stfg_pkg::BK_IDLE;
        end
      end
      stfg_pkg::BK_MAG:      state_nxt = stfg_pkg::BK_ENV;
      stfg_pkg::BK_ENV: begin
        state_nxt = use_env_r ? stfg_pkg::BK_DIV_GO : stfg_pkg::BK_OUT;
      end
      stfg_pkg::BK_DIV_GO:   state_nxt = stfg_pkg::BK_DIV_WAIT;
      stfg_pkg::BK_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = stfg_pkg::BK_OUT;
        end
      end
      stfg_pkg::BK_OUT: begin
        if (slot_free) begin
          state_nxt = stfg_pkg::BK_IDLE;
        end
      end
      default: state_nxt = stfg_pkg::BK_IDLE;
    endcase
  end

  // State outputs: queue pop, divider requests and the output load.
  always_comb begin
    q_pop            = 1'b0;
    load_out         = 1'b0;
    div_req.go       = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.iters    = '0;
    unique case (state_r)
      stfg_pkg::BK_IDLE: begin
        q_pop = q_valid;
      end
      stfg_pkg::BK_STEP_GO: begin
        div_req.go       = 1'b1;
        div_req.dividend = {1'b0, work_freq_r, 32'd0};
        div_req.divisor  = tone_rate;
        div_req.iters    = stfg_pkg::ITERS_STEP;
      end
      stfg_pkg::BK_DIV_GO: begin
        // (mag * m) / (32768 * fade) equals ((mag * m) >> 15) / fade.
        div_req.go       = 1'b1;
        div_req.dividend = {envp_r[stfg_pkg::ENVP_W-1:15], 24'd0};
        div_req.divisor  = {{(stfg_pkg::DIVISOR_W - FADE_W){1'b0}}, fade_r};
        div_req.iters    = stfg_pkg::ITERS_ENV;
      end
      stfg_pkg::BK_OUT: begin
        load_out = slot_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stfg_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      step_r      <= '0;
      position_r  <= '0;
      total_r     <= '0;
      fade_r      <= '0;
    end else begin
      if (q_pop && is_start) begin
        phase_acc_r <= '0;
        position_r  <= '0;
      end
      if (state_r == stfg_pkg::BK_TOTAL) begin
        total_r <= total_sat;
      end
      if (state_r == stfg_pkg::BK_FADE) begin
        fade_r <= fade_nxt;
        if (tone_rate == '0) begin
          step_r <= '0;
        end
      end
      if ((state_r == stfg_pkg::BK_STEP_WAIT) && div_rsp.done) begin
        step_r <= div_rsp.quotient[stfg_pkg::PHASE_W-1:0];
      end
      if (load_out) begin
        position_r  <= position_r + 22'd1;
        phase_acc_r <= phase_acc_r + step_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_mag_r <= QTAB[q_sel];
    rom_neg_r <= rom_addr[LOG2N-1];
    if (q_pop && is_start) begin
      work_prod_r <= q_data.rate_ms;
      work_freq_r <= q_data.freq_hz;
    end
    if (state_r == stfg_pkg::BK_MAG) begin
      mag_r     <= mag_nxt;
      use_env_r <= in_head || in_tail;
      env_m_r   <= in_head ? position_r[FADE_W-1:0] : tail_d[FADE_W-1:0];
    end
    if (state_r == stfg_pkg::BK_ENV) begin
      envp_r <= envp_nxt;
      res_r  <= mag_r[stfg_pkg::MAG_W-1:15];
    end
    if ((state_r == stfg_pkg::BK_DIV_WAIT) && div_rsp.done) begin
      res_r <= div_rsp.quotient[SINE_W-1:0];
    end
    if (load_out) begin
      out_sample_r <= rom_neg_r ? (-res_ext) : res_ext;
      out_last_r   <= (position_r == (total_r - 22'd1));
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = $signed(out_sample_r);
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

### rtl/sine_tone_fade_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                                        | Direction
// --------+----------------------------------------------+----------
// config  | cfg_we, cfg_index, cfg_wdata                 | in
// input   | in_valid, in_stall, in_cmd, in_freq_hz,      | in / stall out
//         | in_duration_ms                               |
// output  | out_valid, out_stall, out_sample, out_last   | out / stall in
//
// A tick that gives a sample with full envelope needs no divide; one in a fade
// region waits on the 24 steps of the serial divider. A start runs the serial
// divide for the phase step; the sample count and fade length come from
// reciprocal multiplies. With a zero rate a start skips that divide and sets a
// zero step, and an idle tick gives no sample. Reset is synchronous and leaves
// the tone empty with the default settings. A two-entry queue takes items while
// the back works, and out_stall on a waiting sample holds the back in BK_OUT.

module sine_tone_fade_generator_core #(
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [stfg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [stfg_pkg::RATE_W-1:0]           cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_cmd,
  input  wire logic [stfg_pkg::FREQ_W-1:0]           in_freq_hz,
  input  wire logic [stfg_pkg::MS_W-1:0]             in_duration_ms,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [stfg_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                                       out_last
);

  logic [stfg_pkg::RATE_W-1:0] tone_rate_r;
  logic [stfg_pkg::AMP_W-1:0]  amplitude_r;

  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  stfg_pkg::q_entry_t q_in;
  stfg_pkg::q_entry_t q_out;
  stfg_pkg::div_req_t div_req;
  stfg_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_rate_r <= stfg_pkg::RATE_RESET;
      amplitude_r <= stfg_pkg::AMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stfg_pkg::REG_SAMPLE_RATE: tone_rate_r <= cfg_wdata;
        stfg_pkg::REG_AMPLITUDE:   amplitude_r <= cfg_wdata[stfg_pkg::AMP_W-1:0];
        default:                   tone_rate_r <= tone_rate_r;
      endcase
    end
  end

  stfg_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_freq_hz     (in_freq_hz),
    .in_duration_ms (in_duration_ms),
    .tone_rate      (tone_rate_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_in)
  );

  stfg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  stfg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  stfg_back #(
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tone_rate   (tone_rate_r),
    .amplitude   (amplitude_r),
    .q_valid     (!q_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire
